// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the range owner table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in every cycle in which the antecedent holds.
`define ROT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("range owner table check failed");

// Checks that a condition holds in every cycle out of reset.
`define ROT_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("range owner table check failed");

`endif

// ----- rtl/rot_pkg.sv -----
// Types and constants shared by the range owner table modules.
package rot_pkg;

    localparam logic [1:0] OP_ADD_POS = 2'd0;
    localparam logic [1:0] OP_ADD_DES = 2'd1;
    localparam logic [1:0] OP_OWNER   = 2'd2;
    localparam logic [1:0] OP_COUNT   = 2'd3;

    localparam logic REG_DECLARED_COUNT = 1'b0;
    localparam logic REG_INFER_BOUND    = 1'b1;

    typedef enum logic [3:0] {
        K_ADD_POS = 4'b0001,
        K_ADD_DES = 4'b0010,
        K_OWNER   = 4'b0100,
        K_COUNT   = 4'b1000
    } t_kind;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] range_first;
        logic [15:0] range_last;
        logic [15:0] query_elem;
        logic [5:0]  query_action;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [5:0]  action_number;
        logic        owner_valid;
        logic [15:0] owned_count;
    } t_result;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] range_first;
        logic [15:0] range_last;
        logic [15:0] query_elem;
        logic [5:0]  query_action;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_head;

endpackage

// ----- rtl/rot_ram.sv -----
// Generic single write port RAM with one registered read port.
module rot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/rot_front.sv -----
// Front end: accepts commands, decodes them and queues them for the back end.
`include "assert_macros.svh"
module rot_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rot_pkg::t_item i_item,
    input  logic           i_pop,
    output rot_pkg::t_head o_head
);
    import rot_pkg::*;

    t_qent      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    t_qent      dec;

    always_comb begin
        dec.range_first  = i_item.range_first;
        dec.range_last   = i_item.range_last;
        dec.query_elem   = i_item.query_elem;
        dec.query_action = i_item.query_action;
        unique case (i_item.operation)
            OP_ADD_POS: dec.kind = K_ADD_POS;
            OP_ADD_DES: dec.kind = K_ADD_DES;
            OP_OWNER:   dec.kind = K_OWNER;
            OP_COUNT:   dec.kind = K_COUNT;
        endcase
    end

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.ent   = r_q[r_rd];

    `ROT_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'd2)
    `ROT_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_cnt != 2'd0)
endmodule

// ----- rtl/rot_back.sv -----
// Back end: keeps the range table and carries out adds, owner and count queries.
`include "assert_macros.svh"
module rot_back #(
    parameter int MAX_ACTIONS = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rot_pkg::t_head   i_head,
    output logic             o_pop,
    input  logic [15:0]      i_declared_count,
    input  logic             i_infer_bound,
    output logic             o_done,
    output rot_pkg::t_result o_result
);
    import rot_pkg::*;

    localparam int IB = INDEX_BITS;
    localparam int AW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int TW = $clog2(MAX_ACTIONS + 1);
    localparam int CW = ((IB > 16) ? IB : 16) + 1;
    localparam logic [IB-1:0] IDX_MASK = {IB{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_OWN     = 5'b00010,
        S_CQ_WAIT = 5'b00100,
        S_CQ_LOAD = 5'b01000,
        S_CQ_SCAN = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [TW-1:0] r_total, n_total;
    logic [IB-1:0] r_next, n_next;
    logic [IB-1:0] r_high, n_high;
    logic          r_done, n_done;
    t_result       r_res, n_res;
    logic [IB-1:0] r_elem, n_elem;
    logic [AW-1:0] r_qa, n_qa;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_chk, n_chk;
    logic          r_pend, n_pend;
    logic [IB-1:0] r_p, n_p;
    logic [IB-1:0] r_hi, n_hi;
    logic [IB-1:0] r_count, n_count;
    logic          r_cov, n_cov;
    logic [IB-1:0] r_jump, n_jump;
    logic [IB-1:0] r_nstart, n_nstart;

    logic            we;
    logic [2*IB-1:0] rd_data;
    logic [IB-1:0]   e_start, e_end;
    logic [CW-1:0]   cnt_eff;
    t_qent           ent;
    logic [IB-1:0]   f_first, f_last, f_elem;
    logic [IB-1:0]   a_first, a_last;
    logic            reject;
    logic [IB-1:0]   hi_c;
    logic            u_cov;
    logic [IB-1:0]   u_jump, u_ns, p_new, c_new;
    logic            last_chk;

    rot_ram #(
        .WIDTH(2 * IB),
        .DEPTH(MAX_ACTIONS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(AW'(r_total)),
        .i_wdata({a_first, a_last}),
        .i_raddr(r_k),
        .o_rdata(rd_data)
    );

    assign e_start = rd_data[2*IB-1:IB];
    assign e_end   = rd_data[IB-1:0];
    assign ent     = i_head.ent;
    assign f_first = IB'(ent.range_first);
    assign f_last  = IB'(ent.range_last);
    assign f_elem  = IB'(ent.query_elem);
    assign cnt_eff = i_infer_bound ? CW'(r_high) : CW'(i_declared_count);
    assign o_pop   = (r_state == S_IDLE) && i_head.valid;

    assign a_first = (ent.kind == K_ADD_POS) ? r_next : f_first;
    assign a_last  = (ent.kind == K_ADD_POS) ? r_next : f_last;
    assign reject  = (a_first > a_last) || (a_last == IDX_MASK)
                     || (!i_infer_bound && (CW'(a_last) >= CW'(i_declared_count)))
                     || (r_total >= TW'(MAX_ACTIONS));
    assign we      = o_pop && ((ent.kind == K_ADD_POS) || (ent.kind == K_ADD_DES))
                     && !reject;

    assign hi_c = ((cnt_eff != '0) && (CW'(e_end) > (cnt_eff - CW'(1))))
                  ? IB'(cnt_eff - CW'(1)) : e_end;

    always_comb begin
        u_cov  = r_cov;
        u_jump = r_jump;
        u_ns   = r_nstart;
        if (r_pend) begin
            if ((r_p >= e_start) && (r_p <= e_end)) begin
                if (!r_cov || (e_end > r_jump)) begin
                    u_jump = e_end;
                end
                u_cov = 1'b1;
            end else if ((e_start > r_p) && (e_start < r_nstart)) begin
                u_ns = e_start;
            end
        end
        if (u_cov) begin
            p_new = u_jump + IB'(1);
            c_new = r_count;
        end else begin
            p_new = u_ns;
            c_new = r_count + (u_ns - r_p);
        end
        last_chk = r_pend && (32'(r_chk) == 32'(r_total) - 32'd1);
    end

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_next   = r_next;
        n_high   = r_high;
        n_done   = 1'b0;
        n_res    = '0;
        n_elem   = r_elem;
        n_qa     = r_qa;
        n_k      = r_k;
        n_chk    = r_chk;
        n_pend   = r_pend;
        n_p      = r_p;
        n_hi     = r_hi;
        n_count  = r_count;
        n_cov    = r_cov;
        n_jump   = r_jump;
        n_nstart = r_nstart;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    unique case (ent.kind)
                        K_ADD_POS, K_ADD_DES: begin
                            n_done = 1'b1;
                            if (reject) begin
                                n_res.status = 1'b1;
                            end else begin
                                n_res.action_number = 6'(r_total);
                                n_total = r_total + TW'(1);
                                n_next  = a_last + IB'(1);
                                if ((a_last + IB'(1)) > r_high) begin
                                    n_high = a_last + IB'(1);
                                end
                            end
                        end
                        K_OWNER: begin
                            if (CW'(f_elem) >= cnt_eff) begin
                                n_done       = 1'b1;
                                n_res.status = 1'b1;
                            end else if (r_total == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_elem  = f_elem;
                                n_k     = AW'(r_total - TW'(1));
                                n_pend  = 1'b0;
                                n_state = S_OWN;
                            end
                        end
                        K_COUNT: begin
                            if (32'(ent.query_action) >= 32'(r_total)) begin
                                n_done       = 1'b1;
                                n_res.status = 1'b1;
                            end else begin
                                n_qa    = AW'(ent.query_action);
                                n_k     = AW'(ent.query_action);
                                n_state = S_CQ_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_OWN: begin
                if (r_pend && (r_elem >= e_start) && (r_elem <= e_end)) begin
                    n_done              = 1'b1;
                    n_res.owner_valid   = 1'b1;
                    n_res.action_number = 6'(r_chk);
                    n_state             = S_IDLE;
                end else if (r_pend && (r_chk == '0)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_chk  = r_k;
                    n_pend = 1'b1;
                    if (r_k != '0) begin
                        n_k = r_k - AW'(1);
                    end
                end
            end
            S_CQ_WAIT: begin
                n_state = S_CQ_LOAD;
            end
            S_CQ_LOAD: begin
                if ((cnt_eff == '0) || (e_start > hi_c)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if ((32'(r_qa) + 32'd1) >= 32'(r_total)) begin
                    n_done            = 1'b1;
                    n_res.owned_count = 16'(hi_c - e_start + IB'(1));
                    n_state           = S_IDLE;
                end else begin
                    n_p      = e_start;
                    n_hi     = hi_c;
                    n_count  = '0;
                    n_k      = r_qa + AW'(1);
                    n_pend   = 1'b0;
                    n_cov    = 1'b0;
                    n_jump   = '0;
                    n_nstart = hi_c + IB'(1);
                    n_state  = S_CQ_SCAN;
                end
            end
            S_CQ_SCAN: begin
                if (last_chk) begin
                    if (p_new <= r_hi) begin
                        n_p      = p_new;
                        n_count  = c_new;
                        n_k      = r_qa + AW'(1);
                        n_pend   = 1'b0;
                        n_cov    = 1'b0;
                        n_jump   = '0;
                        n_nstart = r_hi + IB'(1);
                    end else begin
                        n_done            = 1'b1;
                        n_res.owned_count = 16'(c_new);
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_cov    = u_cov;
                    n_jump   = u_jump;
                    n_nstart = u_ns;
                    n_chk    = r_k;
                    n_pend   = 1'b1;
                    if (32'(r_k) != 32'(r_total) - 32'd1) begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_next  <= '0;
            r_high  <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_next  <= n_next;
            r_high  <= n_high;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_elem   <= n_elem;
        r_qa     <= n_qa;
        r_k      <= n_k;
        r_chk    <= n_chk;
        r_p      <= n_p;
        r_hi     <= n_hi;
        r_count  <= n_count;
        r_cov    <= n_cov;
        r_jump   <= n_jump;
        r_nstart <= n_nstart;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `ROT_ASSERT_ALWAYS(a_total_bound, i_clk, i_rst_n, 32'(r_total) <= MAX_ACTIONS)
    `ROT_ASSERT_IMPL(a_own_nonempty, i_clk, i_rst_n, r_state == S_OWN, r_total != '0)
endmodule

// ----- rtl/range_owner_table.sv -----
// Range owner table top level: configuration registers, command queue and table engine.
// An add is read from the queue head and answered on the registered done output.
// An owner query reads the table newest entry first, one table entry read per cycle.
// A count query fails unless its action exists; else it scans newer actions in passes.
// Commands run one at a time; the two-entry queue takes transfers while one runs.
// Synchronous reset empties the table and clears both registers; RAM contents are kept.
module range_owner_table #(
    parameter int MAX_ACTIONS = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rot_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    output logic             o_done,
    output rot_pkg::t_result o_result
);
    import rot_pkg::*;

    logic [15:0] r_declared_count;
    logic        r_infer_bound;
    t_head       head;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declared_count <= '0;
            r_infer_bound    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DECLARED_COUNT: r_declared_count <= i_cfg_data;
                REG_INFER_BOUND:    r_infer_bound    <= i_cfg_data[0];
            endcase
        end
    end

    rot_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_item (i_item),
        .i_pop  (pop),
        .o_head (head)
    );

    rot_back #(
        .MAX_ACTIONS(MAX_ACTIONS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .i_declared_count(r_declared_count),
        .i_infer_bound   (r_infer_bound),
        .o_done          (o_done),
        .o_result        (o_result)
    );
endmodule
